// ===== sv/rotary_travel_and_homing_assert.svh =====
// ----------------------------------------------------------------------------
// Rotary travel and homing assertion macros
// Shared helpers for the concurrent checks of the rotary travel block.
// ----------------------------------------------------------------------------
`ifndef ROTARY_TRAVEL_AND_HOMING_ASSERT_SVH
`define ROTARY_TRAVEL_AND_HOMING_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define RTH_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rotary travel check failed");

// Next-cycle implication, disabled while reset is high.
`define RTH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rotary travel check failed");

`endif

// ===== sv/rth_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotary travel package
// Types, codes and helpers shared by the rotary travel and homing block.
// ----------------------------------------------------------------------------
package rth_pkg;

  localparam int ANGLE_W    = 9;
  localparam int TOL_W      = 8;
  localparam int TRAVEL_W   = 10;
  localparam int LOCK_W     = 6;
  localparam int DIV_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // A 9-bit sample spans fewer than 32 turns of the smallest supported circle,
  // so five conditional subtractions reduce it.
  localparam int WRAP_STEPS = 5;

  localparam logic [TRAVEL_W-1:0] TRAVEL_MAX = '1;

  typedef enum logic [1:0] {
    DRIVE_STOP = 2'd0,
    DRIVE_CW   = 2'd1,
    DRIVE_CCW  = 2'd2
  } drive_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_DEC  = 2'd1,
    MODE_INC  = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN    = 3'd0,
    CFG_TOLERANCE = 3'd1,
    CFG_TARGET    = 3'd2,
    CFG_LOCKOUT   = 3'd3,
    CFG_DIVIDE    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]  origin_angle;
    logic [TOL_W-1:0]    home_tolerance;
    logic [TRAVEL_W-1:0] travel_target;
    logic [LOCK_W-1:0]   lockout_ticks;
    logic [DIV_W-1:0]    sample_divide;
  } cfg_t;

  typedef struct packed {
    mode_t               mode;
    logic [TRAVEL_W-1:0] travel;
    logic [ANGLE_W-1:0]  prev_angle;
    logic [DIV_W-1:0]    divide_count;
    logic [LOCK_W-1:0]   lockout_count;
    drive_t              drive;
  } track_state_t;

  typedef struct packed {
    drive_t              drive;
    mode_t               move_mode;
    logic [TRAVEL_W-1:0] travel_count;
    logic                at_home;
  } result_t;

  // Reduces a 9-bit angle modulo steps by restoring subtraction.
  function automatic logic [ANGLE_W-1:0] wrap_angle(logic [ANGLE_W-1:0] a,
                                                     logic [ANGLE_W:0] steps);
    logic [ANGLE_W+WRAP_STEPS-1:0] rem;
    logic [ANGLE_W+WRAP_STEPS-1:0] lim;
    rem = (ANGLE_W+WRAP_STEPS)'(a);
    for (int s = WRAP_STEPS - 1; s >= 0; s--) begin
      lim = (ANGLE_W+WRAP_STEPS)'(steps) << s;
      if (rem >= lim) begin
        rem = rem - lim;
      end
    end
    return rem[ANGLE_W-1:0];
  endfunction

endpackage

// ===== sv/rth_in_if.sv =====
// ----------------------------------------------------------------------------
// Rotary travel input channel
// One tick item: angle sample and two move request bits.
// ----------------------------------------------------------------------------
interface rth_in_if import rth_pkg::*;;
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] angle_sample;
  logic               cw_request;
  logic               ccw_request;

  modport source (output valid, output angle_sample, output cw_request,
                  output ccw_request, input ready);
  modport sink   (input valid, input angle_sample, input cw_request,
                  input ccw_request, output ready);
endinterface

// ===== sv/rth_out_if.sv =====
// ----------------------------------------------------------------------------
// Rotary travel output channel
// One result item per tick: drive, mode, travel count and home flag.
// ----------------------------------------------------------------------------
interface rth_out_if import rth_pkg::*;;
  logic                valid;
  logic                ready;
  logic [1:0]          drive;
  logic [1:0]          move_mode;
  logic [TRAVEL_W-1:0] travel_count;
  logic                at_home;

  modport source (output valid, output drive, output move_mode,
                  output travel_count, output at_home, input ready);
  modport sink   (input valid, input drive, input move_mode,
                  input travel_count, input at_home, output ready);
endinterface

// ===== sv/rth_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Rotary travel configuration channel
// Register write item: register index and write data.
// ----------------------------------------------------------------------------
interface rth_cfg_if import rth_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/rotary_travel_and_homing.sv =====
// ----------------------------------------------------------------------------
// Rotary travel and homing
// Counts shaft travel during requested moves and steers home while idle.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one tick item per handshake: an angle sample in degrees and
//   the clockwise and counterclockwise request bits. out_ch returns exactly
//   one result item per tick: drive, move mode, travel count and home flag.
//   cfg writes one of the five setup registers by index; it is always ready,
//   and registers should be changed only while no tick is in flight.
//   A tick is held in an input register, worked through the step logic, and
//   its result is held in the result register and offered on out_ch. The
//   input register and the result register form a two-entry pipeline, so
//   one tick per cycle is sustained while out_ch does not stall.
//   When out_ch stalls, the result register holds, the input register holds
//   the next tick, and in_ch drops ready once both are full.
//   Synchronous reset empties the pipeline, returns the tracking state to
//   idle with the drive stopped, and loads the register defaults.
// ----------------------------------------------------------------------------
`include "rotary_travel_and_homing_assert.svh"

module rotary_travel_and_homing import rth_pkg::*; #(
  parameter int ANGLE_STEPS = 360
) (
  input  logic clk,
  input  logic rst,
  rth_in_if.sink    in_ch,
  rth_out_if.source out_ch,
  rth_cfg_if.sink   cfg
);

  cfg_t               regs;
  logic               s1_valid;
  logic [ANGLE_W-1:0] s1_angle;
  logic               s1_cw;
  logic               s1_ccw;
  logic               s1_fire;
  track_state_t       state;
  track_state_t       state_next;
  result_t            step_res;
  logic               out_valid;
  result_t            out_res;

  rth_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  rth_track #(
    .ANGLE_STEPS (ANGLE_STEPS)
  ) u_track (
    .cfg          (regs),
    .cur          (state),
    .angle_sample (s1_angle),
    .cw_request   (s1_cw),
    .ccw_request  (s1_ccw),
    .nxt          (state_next),
    .res          (step_res)
  );

  assign s1_fire     = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_angle <= in_ch.angle_sample;
      s1_cw    <= in_ch.cw_request;
      s1_ccw   <= in_ch.ccw_request;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res <= step_res;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.drive        = out_res.drive;
  assign out_ch.move_mode    = out_res.move_mode;
  assign out_ch.travel_count = out_res.travel_count;
  assign out_ch.at_home      = out_res.at_home;

  `RTH_ASSERT_NOW(a_home_only_idle, clk, rst, out_valid && out_res.at_home,
                  out_res.move_mode == MODE_IDLE)
  `RTH_ASSERT_NOW(a_home_stops, clk, rst, out_valid && out_res.at_home,
                  out_res.drive == DRIVE_STOP)
  `RTH_ASSERT_NEXT(a_lockout_counts, clk, rst,
                   s1_fire && (state.lockout_count != '0),
                   state.lockout_count == LOCK_W'($past(state.lockout_count) - 1'b1))
  `RTH_ASSERT_NEXT(a_tick_kept, clk, rst, s1_valid && !s1_fire, s1_valid)

endmodule

// ===== sv/rth_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Rotary travel configuration registers
// Holds the five setup registers and takes a write every cycle.
// ----------------------------------------------------------------------------
module rth_cfg_regs import rth_pkg::*; (
  input  logic clk,
  input  logic rst,
  rth_cfg_if.sink cfg,
  output cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.origin_angle   <= ANGLE_W'(0);
      regs.home_tolerance <= TOL_W'(10);
      regs.travel_target  <= TRAVEL_W'(355);
      regs.lockout_ticks  <= LOCK_W'(50);
      regs.sample_divide  <= DIV_W'(2);
    end else if (cfg.valid) begin
      case (cfg_idx_t'(cfg.index))
        CFG_ORIGIN:    regs.origin_angle   <= cfg.data[ANGLE_W-1:0];
        CFG_TOLERANCE: regs.home_tolerance <= cfg.data[TOL_W-1:0];
        CFG_TARGET:    regs.travel_target  <= cfg.data[TRAVEL_W-1:0];
        CFG_LOCKOUT:   regs.lockout_ticks  <= cfg.data[LOCK_W-1:0];
        CFG_DIVIDE:    regs.sample_divide  <= cfg.data[DIV_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sv/rth_track.sv =====
// ----------------------------------------------------------------------------
// Rotary travel step logic
// Computes the next tracking state and the result for one tick.
// ----------------------------------------------------------------------------
module rth_track import rth_pkg::*; #(
  parameter int ANGLE_STEPS = 360
) (
  input  cfg_t               cfg,
  input  track_state_t       cur,
  input  logic [ANGLE_W-1:0] angle_sample,
  input  logic               cw_request,
  input  logic               ccw_request,
  output track_state_t       nxt,
  output result_t            res
);

  localparam logic [ANGLE_W:0] STEPS = (ANGLE_W+1)'(ANGLE_STEPS);
  localparam logic [ANGLE_W:0] HALF  = (ANGLE_W+1)'(ANGLE_STEPS / 2);

  // Wrapped travel going up from one angle to the next.
  function automatic logic [ANGLE_W-1:0] step_travel(logic [ANGLE_W-1:0] from,
                                                      logic [ANGLE_W-1:0] to);
    logic [ANGLE_W:0] wrapped;
    wrapped = STEPS - (ANGLE_W+1)'(from) + (ANGLE_W+1)'(to);
    if (to > from) begin
      return to - from;
    end else if (to == from) begin
      return '0;
    end else begin
      return wrapped[ANGLE_W-1:0];
    end
  endfunction

  logic [ANGLE_W-1:0]  angle;
  logic [ANGLE_W-1:0]  origin;
  logic                take_req;
  mode_t               mode_req;
  logic [TRAVEL_W-1:0] travel_req;
  logic [ANGLE_W-1:0]  prev_req;
  logic [ANGLE_W-1:0]  add;
  logic [TRAVEL_W:0]   sum;
  logic [TRAVEL_W-1:0] travel_sat;
  logic [ANGLE_W+1:0]  dev_sum;
  logic [ANGLE_W:0]    dev;
  logic [ANGLE_W:0]    tol;
  logic                near_home;

  assign angle  = wrap_angle(angle_sample, STEPS);
  assign origin = wrap_angle(cfg.origin_angle, STEPS);

  // A request is honored only once the lockout has run out.
  assign take_req   = (cur.lockout_count == '0) && (cw_request || ccw_request);
  assign mode_req   = take_req ? (ccw_request ? MODE_INC : MODE_DEC) : cur.mode;
  assign travel_req = take_req ? '0 : cur.travel;
  assign prev_req   = take_req ? angle : cur.prev_angle;

  assign add = (mode_req == MODE_INC) ? step_travel(prev_req, angle)
                                      : step_travel(angle, prev_req);
  assign sum = (TRAVEL_W+1)'(travel_req) + (TRAVEL_W+1)'(add);
  assign travel_sat = sum[TRAVEL_W] ? TRAVEL_MAX : sum[TRAVEL_W-1:0];

  // Both operands are below one turn, so one subtraction finishes the wrap.
  assign dev_sum = (ANGLE_W+2)'(angle) + (ANGLE_W+2)'(STEPS) - (ANGLE_W+2)'(origin);
  assign dev = (dev_sum >= (ANGLE_W+2)'(STEPS))
             ? (ANGLE_W+1)'(dev_sum - (ANGLE_W+2)'(STEPS))
             : dev_sum[ANGLE_W:0];
  assign tol = (ANGLE_W+1)'(cfg.home_tolerance);
  assign near_home = (dev <= tol) || ((STEPS - dev) <= tol);

  always_comb begin
    nxt        = cur;
    res.at_home = 1'b0;

    if (cur.lockout_count != '0) begin
      nxt.lockout_count = cur.lockout_count - 1'b1;
    end else if (take_req) begin
      nxt.lockout_count = cfg.lockout_ticks;
    end

    nxt.mode       = mode_req;
    nxt.travel     = travel_req;
    nxt.prev_angle = prev_req;

    if (mode_req != MODE_IDLE) begin
      if (cur.divide_count < cfg.sample_divide) begin
        nxt.divide_count = cur.divide_count + 1'b1;
      end else begin
        nxt.divide_count = '0;
        nxt.travel       = travel_sat;
        nxt.prev_angle   = angle;
        if (travel_sat >= cfg.travel_target) begin
          nxt.mode = MODE_IDLE;
        end
        case (nxt.mode)
          MODE_DEC: nxt.drive = DRIVE_CW;
          MODE_INC: nxt.drive = DRIVE_CCW;
          default:  nxt.drive = DRIVE_STOP;
        endcase
      end
    end

    // Idle steering; exactly half a turn away leaves the drive unchanged.
    if (nxt.mode == MODE_IDLE) begin
      nxt.prev_angle = angle;
      if (near_home) begin
        nxt.drive   = DRIVE_STOP;
        res.at_home = 1'b1;
      end else if (dev > HALF) begin
        nxt.drive = DRIVE_CCW;
      end else if (dev < HALF) begin
        nxt.drive = DRIVE_CW;
      end
    end

    res.drive        = nxt.drive;
    res.move_mode    = nxt.mode;
    res.travel_count = nxt.travel;
  end

endmodule
